@@ hdl/pl0_pkg.sv @@
// ----------------------------------------------------------------------------
// PL/0 core package
// Shared types and constants for the p-code stack machine core.
// ----------------------------------------------------------------------------
`default_nettype none
package pl0_pkg;
  localparam int STACK_DEPTH = 1024;
  localparam int CODE_DEPTH  = 1024;
  localparam int DATA_WIDTH  = 32;
  localparam int MAX_LEVEL   = 31;
  localparam int SA_W        = $clog2(STACK_DEPTH);
  localparam int PC_W        = $clog2(CODE_DEPTH);

  localparam logic [3:0] OP_LIT = 4'd0, OP_OPR = 4'd1, OP_LOD = 4'd2, OP_STO = 4'd3,
                         OP_CAL = 4'd4, OP_INT = 4'd5, OP_JMP = 4'd6, OP_JPC = 4'd7,
                         OP_RD  = 4'd8, OP_WR  = 4'd9;

  localparam logic [4:0] F_RET = 5'd0, F_NEG = 5'd1, F_ADD = 5'd2, F_SUB = 5'd3,
                         F_MUL = 5'd4, F_DIV = 5'd5, F_ODD = 5'd6, F_EQ = 5'd7,
                         F_NE = 5'd8, F_LT = 5'd9, F_LE = 5'd10, F_GT = 5'd11,
                         F_GE = 5'd12, F_NL = 5'd13, F_WRT = 5'd14, F_MOD = 5'd15,
                         F_ADD2 = 5'd16, F_SUB2 = 5'd17, F_INC = 5'd18,
                         F_DEC = 5'd19, F_SHL = 5'd20, F_SHR = 5'd21, F_NOT = 5'd22;

  localparam logic [1:0] FLT_NONE = 2'd0, FLT_DIV0 = 2'd1, FLT_STACK = 2'd2;

  typedef struct packed {
    logic [3:0]  operation;
    logic [4:0]  level_diff;
    logic signed [31:0] operand;
    logic signed [31:0] read_value;
  } pl0_in_t;

  typedef struct packed {
    logic [9:0]  next_pc;
    logic        out_valid;
    logic        out_kind;
    logic signed [31:0] out_value;
    logic        halted;
    logic [1:0]  fault;
  } pl0_out_t;
endpackage
`default_nettype wire

@@ hdl/pl0_stack_machine_core.sv @@
// ----------------------------------------------------------------------------
// PL/0 stack machine core
// Executes one fetched p-code instruction per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one instruction (operation, level, operand, READ
//   value); out_valid/out_stall carry one status transaction per instruction.
//   Every instruction, unless the core is halted, goes through a sequencer
//   that reads the stack memory one word at a time: the static link walk
//   reads one word per level. Each stack write adds a write state after
//   execution (three writes for CAL); after the result is taken the core
//   returns to idle before it takes the next instruction. MUL uses a
//   1-bit-per-cycle shift-add unit and DIV/MOD a restoring divider; both
//   iterate over every operand bit before the write-back. After reset a
//   clearing pass writes zero to all 1024 stack words before the first
//   instruction is accepted. A result waits in the output register while
//   out_stall is high; the core accepts nothing until it is taken. Once
//   halted, every instruction just returns the held pc, halted and the
//   latched fault.
// ----------------------------------------------------------------------------
`default_nettype none
module pl0_stack_machine_core
  import pl0_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire pl0_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pl0_out_t      out_data
);
  localparam int DW = DATA_WIDTH;
  localparam int CW = $clog2(DW + 1);

  typedef enum logic [11:0] {
    S_CLR  = 12'b000000000001,
    S_IDLE = 12'b000000000010,
    S_WALK = 12'b000000000100,
    S_WWT  = 12'b000000001000,
    S_RD0  = 12'b000000010000,
    S_RD0W = 12'b000000100000,
    S_RD1  = 12'b000001000000,
    S_RD1W = 12'b000010000000,
    S_EXEC = 12'b000100000000,
    S_ITER = 12'b001000000000,
    S_WB   = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } st_t;

  st_t st_r, st_nxt;
  logic [DW-1:0] mem [STACK_DEPTH];
  logic [DW-1:0] rdata_r;
  logic          we;
  logic [SA_W-1:0] waddr, raddr;
  logic [DW-1:0] wdata;

  pl0_in_t ins_r;
  logic [SA_W:0] clr_r;
  logic [SA_W-1:0] top_r, base_r, a_r;
  logic [PC_W-1:0] pc_r;
  logic stop_r;
  logic [1:0] cause_r;
  logic [4:0] lvl_r;
  logic [DW-1:0] x_r, y_r, r_r;
  logic [DW-1:0] acc_r, rem_r;
  logic [CW-1:0] cnt_r;
  logic [1:0] wb_r;       // remaining writes (CAL needs three)
  logic       out_v_r;
  pl0_out_t   out_r;

  logic [4:0] fn;
  logic [SA_W+33:0] t_s, a_s;
  logic signed [SA_W+33:0] eff;
  assign fn = ins_r.operand[4:0];
  assign t_s = {{34{1'b0}}, top_r};
  assign a_s = {{34{1'b0}}, a_r};
  assign eff = $signed(a_s) + $signed({{SA_W+2{ins_r.operand[31]}}, ins_r.operand});

  function automatic logic ok(input logic signed [SA_W+33:0] v);
    return (v >= 0) && (v < STACK_DEPTH);
  endfunction

  logic opr_bin, opr_un;
  always_comb begin
    opr_un  = (ins_r.operand == 32'(F_NEG)) || (ins_r.operand == 32'(F_ODD)) ||
              (ins_r.operand == 32'(F_INC)) || (ins_r.operand == 32'(F_DEC)) ||
              (ins_r.operand == 32'(F_NOT));
    opr_bin = (ins_r.operand[31:5] == '0) && ((fn >= F_ADD && fn <= F_DIV) ||
              (fn >= F_EQ && fn <= F_GE) || (fn >= F_MOD && fn <= F_SUB2) ||
              fn == F_SHL || fn == F_SHR);
  end

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // divider step: trial subtraction of the divisor magnitude from the partial remainder
  logic [DW:0] dsub;
  logic [DW-1:0] ax, ay;
  assign ax = x_r[DW-1] ? (~x_r + 1'b1) : x_r;
  assign ay = y_r[DW-1] ? (~y_r + 1'b1) : y_r;
  assign dsub = {rem_r, acc_r[DW-1]} - {1'b0, ay};

  logic is_md;
  assign is_md = (fn == F_MUL) || (fn == F_DIV) || (fn == F_MOD);

  // ALU for the operators that need no iteration
  logic [DW-1:0] alu;
  logic [DW-1:0] ybig;
  logic ysat;
  assign ysat = (y_r >= DW);
  always_comb begin
    ybig = '0;
    case (fn)
      F_NEG: alu = ~x_r + 1'b1;
      F_ODD: alu = x_r[0] ? (x_r[DW-1] ? '1 : DW'(1)) : '0;
      F_INC: alu = x_r + 1'b1;
      F_DEC: alu = x_r - 1'b1;
      F_NOT: alu = DW'(x_r == '0);
      F_ADD, F_ADD2: alu = x_r + y_r;
      F_SUB, F_SUB2: alu = x_r - y_r;
      F_EQ: alu = DW'(x_r == y_r);
      F_NE: alu = DW'(x_r != y_r);
      F_LT: alu = DW'($signed(x_r) < $signed(y_r));
      F_LE: alu = DW'($signed(x_r) <= $signed(y_r));
      F_GT: alu = DW'($signed(x_r) > $signed(y_r));
      F_GE: alu = DW'($signed(x_r) >= $signed(y_r));
      F_SHL: alu = ysat ? '0 : (x_r << y_r[CW-2:0]);
      F_SHR: begin
        ybig = {DW{x_r[DW-1]}};
        alu = ysat ? ybig : DW'($signed(x_r) >>> y_r[CW-2:0]);
      end
      default: alu = '0;
    endcase
  end

  // next-state and datapath
  logic [SA_W-1:0] top_nxt, base_nxt, a_nxt;
  logic [PC_W-1:0] pc_nxt, pc1, tgt;
  logic stop_nxt;
  logic [1:0] cause_nxt;
  logic [4:0] lvl_nxt;
  logic [DW-1:0] x_nxt, y_nxt, r_nxt, acc_nxt, rem_nxt;
  logic [CW-1:0] cnt_nxt;
  logic [1:0] wb_nxt;
  logic out_v_nxt;
  pl0_out_t out_nxt;
  pl0_in_t ins_nxt;
  logic [SA_W:0] clr_nxt;

  assign pc1 = pc_r + 1'b1;
  assign tgt = ins_r.operand[PC_W-1:0];

  always_comb begin
    st_nxt = st_r; top_nxt = top_r; base_nxt = base_r; a_nxt = a_r; pc_nxt = pc_r;
    stop_nxt = stop_r; cause_nxt = cause_r; lvl_nxt = lvl_r; x_nxt = x_r; y_nxt = y_r;
    r_nxt = r_r; acc_nxt = acc_r; rem_nxt = rem_r; cnt_nxt = cnt_r; wb_nxt = wb_r;
    out_v_nxt = out_v_r; out_nxt = out_r; ins_nxt = ins_r; clr_nxt = clr_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = top_r;
    unique case (st_r)
      S_CLR: begin
        we = 1'b1; waddr = clr_r[SA_W-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (SA_W+1)'(STACK_DEPTH - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          ins_nxt = in_data;
          lvl_nxt = in_data.level_diff;
          a_nxt = base_r;
          out_nxt = '0;
          out_nxt.next_pc = pc1;
          if (stop_r) begin
            out_nxt.next_pc = pc_r; out_nxt.halted = 1'b1; out_nxt.fault = cause_r;
            out_v_nxt = 1'b1; st_nxt = S_OUT;
          end else st_nxt = S_WALK;
        end
      end
      S_WALK: begin
        raddr = a_r;
        if (lvl_r == '0) st_nxt = S_RD0;
        else st_nxt = S_WWT;
      end
      S_WWT: begin
        if (rdata_r >= STACK_DEPTH && (ins_r.operation == OP_LOD ||
            ins_r.operation == OP_STO || ins_r.operation == OP_CAL ||
            ins_r.operation == OP_RD || ins_r.operation == OP_WR)) begin
          cause_nxt = FLT_STACK; st_nxt = S_EXEC;
        end else begin
          a_nxt = rdata_r[SA_W-1:0]; lvl_nxt = lvl_r - 1'b1; st_nxt = S_WALK;
        end
      end
      S_RD0: begin
        // first operand: top, base+1 for RET, a+opv for LOD/WRITE
        raddr = top_r;
        if (ins_r.operation == OP_LOD || ins_r.operation == OP_WR) raddr = eff[SA_W-1:0];
        if (ins_r.operation == OP_OPR && ins_r.operand == 32'(F_RET))
          raddr = base_r + 1'b1;
        st_nxt = S_RD0W;
      end
      S_RD0W: begin
        y_nxt = rdata_r; x_nxt = rdata_r; st_nxt = S_RD1;
      end
      S_RD1: begin
        raddr = top_r - 1'b1;
        if (ins_r.operation == OP_OPR && ins_r.operand == 32'(F_RET))
          raddr = base_r + 2'd2;
        st_nxt = S_RD1W;
      end
      S_RD1W: begin
        if (ins_r.operation == OP_OPR && opr_bin) x_nxt = rdata_r;
        else if (ins_r.operation == OP_OPR && ins_r.operand == 32'(F_RET)) r_nxt = rdata_r;
        st_nxt = S_EXEC;
      end
      S_EXEC: begin
        st_nxt = S_OUT; out_v_nxt = 1'b1; wb_nxt = '0;
        if (cause_r != FLT_NONE && !stop_r) begin
          out_nxt.next_pc = pc_r; out_nxt.halted = 1'b1; out_nxt.fault = cause_r;
          stop_nxt = 1'b1;
        end else begin
          pc_nxt = pc1;
          case (ins_r.operation)
            OP_LIT: if (!ok(t_s + 1)) cause_nxt = FLT_STACK;
              else begin top_nxt = top_r + 1'b1; r_nxt = ins_r.operand; wb_nxt = 2'd1; end
            OP_LOD: if (!ok(eff) || !ok(t_s + 1)) cause_nxt = FLT_STACK;
              else begin top_nxt = top_r + 1'b1; r_nxt = y_r; wb_nxt = 2'd1; end
            OP_STO: if (!ok(eff) || !ok(t_s - 1)) cause_nxt = FLT_STACK;
              else begin
                top_nxt = top_r - 1'b1; r_nxt = y_r; wb_nxt = 2'd1;
                out_nxt.out_valid = 1'b1; out_nxt.out_value = y_r;
              end
            OP_CAL: if (!ok(t_s + 3)) cause_nxt = FLT_STACK;
              else begin
                // hold the caller's base and return address for the frame writes
                wb_nxt = 2'd3; pc_nxt = tgt;
                x_nxt = DW'(base_r); r_nxt = DW'(pc1);
              end
            OP_INT: if (!ok($signed(t_s) + $signed({{SA_W+2{ins_r.operand[31]}},
                        ins_r.operand}))) cause_nxt = FLT_STACK;
              else top_nxt = top_r + ins_r.operand[SA_W-1:0];
            OP_JMP: pc_nxt = tgt;
            OP_JPC: if (!ok(t_s - 1)) cause_nxt = FLT_STACK;
              else begin top_nxt = top_r - 1'b1; if (y_r == '0) pc_nxt = tgt; end
            OP_RD: if (!ok(eff)) cause_nxt = FLT_STACK;
              else begin r_nxt = ins_r.read_value; wb_nxt = 2'd1; end
            OP_WR: if (!ok(eff)) cause_nxt = FLT_STACK;
              else begin out_nxt.out_valid = 1'b1; out_nxt.out_value = y_r; end
            OP_OPR: begin
              if (ins_r.operand == 32'(F_RET)) begin
                if (base_r == '0 || base_r > SA_W'(STACK_DEPTH - 3) || y_r >= STACK_DEPTH)
                  cause_nxt = FLT_STACK;
                else begin
                  top_nxt = base_r - 1'b1; pc_nxt = r_r[PC_W-1:0];
                  base_nxt = y_r[SA_W-1:0];
                end
              end else if (opr_un) begin
                r_nxt = alu; wb_nxt = 2'd1;
              end else if (ins_r.operand == 32'(F_NL)) begin
                out_nxt.out_valid = 1'b1; out_nxt.out_kind = 1'b1;
              end else if (ins_r.operand == 32'(F_WRT)) begin
                if (!ok(t_s - 1)) cause_nxt = FLT_STACK;
                else begin
                  top_nxt = top_r - 1'b1; out_nxt.out_valid = 1'b1;
                  out_nxt.out_value = y_r;
                end
              end else if (opr_bin) begin
                if (!ok(t_s - 1)) cause_nxt = FLT_STACK;
                else if ((fn == F_DIV || fn == F_MOD) && y_r == '0) cause_nxt = FLT_DIV0;
                else begin
                  top_nxt = top_r - 1'b1; wb_nxt = 2'd1; r_nxt = alu;
                  if (is_md) begin
                    st_nxt = S_ITER; out_v_nxt = 1'b0; cnt_nxt = CW'(DW);
                    acc_nxt = (fn == F_MUL) ? '0 : ax; rem_nxt = '0;
                  end
                end
              end
            end
            default: ;
          endcase
          if (cause_nxt != FLT_NONE) begin
            pc_nxt = pc_r; top_nxt = top_r; base_nxt = base_r; wb_nxt = '0;
            stop_nxt = 1'b1; st_nxt = S_OUT; out_v_nxt = 1'b1;
            out_nxt = '0; out_nxt.next_pc = pc_r; out_nxt.halted = 1'b1;
            out_nxt.fault = cause_nxt;
          end else begin
            if (ins_r.operation == OP_CAL) base_nxt = top_r + 1'b1;
            out_nxt.next_pc = pc_nxt;
            if (pc_nxt == '0) begin stop_nxt = 1'b1; out_nxt.halted = 1'b1; end
            if (wb_nxt != '0 && st_nxt == S_OUT) begin st_nxt = S_WB; out_v_nxt = 1'b0; end
          end
        end
      end
      S_ITER: begin
        // one bit per cycle: shift-add multiply or restoring divide
        cnt_nxt = cnt_r - 1'b1;
        if (fn == F_MUL) begin
          acc_nxt = (acc_r << 1) + (y_r[cnt_r[CW-2:0] - 1'b1] ? x_r : '0);
        end else begin
          if (!dsub[DW]) rem_nxt = dsub[DW-1:0];
          else rem_nxt = {rem_r[DW-2:0], acc_r[DW-1]};
          acc_nxt = {acc_r[DW-2:0], ~dsub[DW]};
        end
        if (cnt_r == CW'(1)) begin
          st_nxt = S_WB;
          if (fn == F_MUL) r_nxt = acc_nxt;
          else if (fn == F_DIV) r_nxt = (x_r[DW-1] ^ y_r[DW-1]) ? (~acc_nxt + 1'b1) : acc_nxt;
          else r_nxt = x_r[DW-1] ? (~rem_nxt + 1'b1) : rem_nxt;
        end
      end
      S_WB: begin
        we = 1'b1; wdata = r_r;
        case (ins_r.operation)
          OP_LIT, OP_LOD: waddr = top_r;
          OP_STO, OP_RD: waddr = eff[SA_W-1:0];
          OP_CAL: begin
            // write static link, dynamic link, return address in turn
            waddr = top_r + 3'd4 - SA_W'(wb_r);
            wdata = (wb_r == 2'd3) ? DW'(a_r) :
                    (wb_r == 2'd2) ? x_r : r_r;
          end
          OP_OPR: waddr = top_r;
          default: waddr = top_r;
        endcase
        wb_nxt = wb_r - 1'b1;
        if (wb_r == 2'd1) begin st_nxt = S_OUT; out_v_nxt = 1'b1; end
      end
      S_OUT: begin
        if (!out_stall) begin out_v_nxt = 1'b0; st_nxt = S_IDLE; end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; top_r <= SA_W'(3); base_r <= SA_W'(1); pc_r <= '0;
      stop_r <= 1'b0; cause_r <= FLT_NONE; out_v_r <= 1'b0; wb_r <= '0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; top_r <= top_nxt; base_r <= base_nxt;
      pc_r <= pc_nxt; stop_r <= stop_nxt; cause_r <= cause_nxt; out_v_r <= out_v_nxt;
      wb_r <= wb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r <= ins_nxt; a_r <= a_nxt; lvl_r <= lvl_nxt; x_r <= x_nxt; y_r <= y_nxt;
    r_r <= r_nxt;
    acc_r <= acc_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt; out_r <= out_nxt;
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (st_r == S_OUT)) else $error("result shown outside output state");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(stop_r) |-> stop_r) else $error("halt cleared");
endmodule
`default_nettype wire
